### src/assert_macros.svh
// Assertion macros used by the checker file of the slot pool allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SPA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define SPA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/spa_pkg.sv
// Package for the slot pool allocator: request codes, status codes and result layout.
// No dependencies; used by the top level and its checker.
package spa_pkg;

  localparam int unsigned SlotW   = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutW    = 32;

  typedef enum logic [OpW-1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  // Result layout, lowest field last.
  typedef struct packed {
    logic [CountW-1:0] peak_count;
    logic [CountW-1:0] live_count;
    logic              is_allocated;
    status_e           status;
    logic [SlotW-1:0]  granted_slot;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

### src/spa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module spa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/slot_pool_allocator_unit.sv
// Slot pool allocator: free-stack slot allocator with an allocated-slot bitmap in RAM.
// S_IDLE accepts a request and issues the stack and bitmap RAM reads; S_EXEC decides,
// writes back and registers the result (m_axis_tvalid). S_EXEC must end before the
// next request is taken (RAM read-modify-write), so a stalled result holds it back.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every bitmap entry
// and no request is accepted until it ends. Depends on spa_pkg, spa_ram.
module slot_pool_allocator_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [spa_pkg::InDataW-1:0] s_axis_tdata, // [7:0] slot_index
  input  logic [spa_pkg::OpW-1:0]    s_axis_tuser,  // [1:0] operation
  // result channel
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] granted_slot, [9:8] status, [10] is_allocated,
  // [19:11] live_count, [28:20] peak_count, [31:29] zero
  output logic [spa_pkg::OutW-1:0]   m_axis_tdata
);

  import spa_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapVal  = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0; // bitmap clearing pass after reset
  localparam logic [1:0] S_IDLE  = 2'd1; // ready for a request, RAM reads issued on accept
  localparam logic [1:0] S_EXEC  = 2'd2; // RAM data back: decide, write back, load result

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // allocator state kept in registers
  logic [CntW-1:0] free_depth_q, free_depth_d;
  logic [CntW-1:0] live_q, live_d;
  logic [CntW-1:0] peak_q, peak_d;

  // captured request
  op_e              op_q;
  logic [SlotW-1:0] idx_q;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic accept, fire;

  // RAM ports
  logic            map_we, map_wdata, map_rdata;
  logic [IdxW-1:0] map_waddr;
  logic            stk_we;
  logic [IdxW-1:0] stk_waddr;
  logic [SlotW-1:0] stk_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // the result register is free, or is being drained this cycle
  assign fire          = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  // Allocated bitmap: read at the request's slot, written on reserve/release
  // and by the clearing pass.
  spa_ram #(
    .Width (1),
    .Depth (CAPACITY)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (accept),
    .raddr_i (IdxW'(s_axis_tdata)),
    .rdata_o (map_rdata)
  );

  // Free stack: top entry is read on every accept, release pushes at the depth.
  // Entries at or above the depth are never consumed.
  spa_ram #(
    .Width (SlotW),
    .Depth (CAPACITY)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (idx_q),
    .re_i    (accept),
    .raddr_i (IdxW'(free_depth_q - 1'b1)),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    logic            in_range;
    logic [IdxW-1:0] slot;

    state_d      = state_q;
    clr_d        = clr_q;
    free_depth_d = free_depth_q;
    live_d       = live_q;
    peak_d       = peak_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_d        = out_q;

    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = IdxW'(free_depth_q);

    in_range = (32'(idx_q) < CAPACITY);
    slot     = IdxW'(idx_q);

    unique case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d            = S_IDLE;
          out_valid_d        = 1'b1;
          out_d.granted_slot = idx_q;
          out_d.status       = STAT_DONE;
          out_d.is_allocated = 1'b0;

          case (op_q)
            OP_RESERVE: begin
              if (live_q >= CapVal) begin
                out_d.status       = STAT_FULL;
                out_d.granted_slot = '0;
              end else begin
                // recycle the most recently freed slot, else the next fresh one
                if (free_depth_q != '0) begin
                  slot         = IdxW'(stk_rdata);
                  free_depth_d = free_depth_q - 1'b1;
                end else begin
                  slot = IdxW'(live_q);
                end
                map_we             = 1'b1;
                map_waddr          = slot;
                map_wdata          = 1'b1;
                live_d             = live_q + 1'b1;
                out_d.granted_slot = SlotW'(slot);
                out_d.is_allocated = 1'b1;
              end
            end
            OP_RELEASE: begin
              if (live_q == '0) begin
                out_d.status       = STAT_IGNORED;
                out_d.is_allocated = in_range && map_rdata;
              end else if (!in_range) begin
                out_d.status = STAT_RANGE;
              end else if (!map_rdata) begin
                out_d.status = STAT_IGNORED;
              end else begin
                // push is dropped on a full stack, the mark is still cleared
                if (free_depth_q < CapVal) begin
                  stk_we       = 1'b1;
                  free_depth_d = free_depth_q + 1'b1;
                end
                map_we    = 1'b1;
                map_waddr = slot;
                map_wdata = 1'b0;
                live_d    = live_q - 1'b1;
              end
            end
            OP_LOOKUP: begin
              if (!in_range) begin
                out_d.status = STAT_RANGE;
              end else begin
                out_d.is_allocated = map_rdata;
              end
            end
            default: ; // unused code: echo only
          endcase

          if (live_d > peak_q) begin
            peak_d = live_d;
          end
          out_d.live_count = CountW'(live_d);
          out_d.peak_count = CountW'(peak_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      free_depth_q <= '0;
      live_q       <= '0;
      peak_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      free_depth_q <= free_depth_d;
      live_q       <= live_d;
      peak_q       <= peak_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      op_q  <= op_e'(s_axis_tuser);
      idx_q <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutW - ResultW)'(0), out_q};

endmodule

### src/spa_checker.sv
// Port-level checker for the slot pool allocator, bound to the top level.
// Depends on spa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [spa_pkg::OutW-1:0]    m_axis_tdata
);

  import spa_pkg::*;

  result_t res;
  logic    req_acc;

  assign res     = result_t'(m_axis_tdata[ResultW-1:0]);
  assign req_acc = s_axis_tvalid && s_axis_tready;

  // no result is shown while reset is held
  `SPA_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid)

  // one request in flight: ready drops right after an accept
  `SPA_ASSERT(a_one_in_flight, clk_i, rst_ni, req_acc |=> !s_axis_tready)

  // a stalled result keeps its payload
  `SPA_ASSERT(a_stall_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // a refused reserve hands out nothing
  `SPA_ASSERT(a_full_no_grant, clk_i, rst_ni,
    m_axis_tvalid && res.status == STAT_FULL |-> res.granted_slot == '0 && !res.is_allocated)

  // the peak mark never trails the live count
  `SPA_ASSERT(a_peak_covers_live, clk_i, rst_ni,
    m_axis_tvalid |-> res.live_count <= res.peak_count)

endmodule

bind slot_pool_allocator_unit spa_checker u_spa_checker (.*);

### bench/tb_slot_pool_allocator_unit.sv
// Self-checking bench for slot_pool_allocator_unit: a directed opener, then phased
// random fill/drain traffic, with a scoreboard that predicts every result.
// Depends on spa_pkg and the RTL under src only.
module tb_slot_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam int unsigned Capacity   = 256;
  localparam int unsigned RandItems  = 1450;
  localparam int unsigned PhaseLen   = 290;
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutW-1:0]     m_axis_tdata;

  // Scoreboard: mirrors the allocator state, queues the predicted result of each
  // accepted request and checks results in order.
  class slot_ledger;
    bit [Capacity-1:0]   taken;
    logic [SlotW-1:0]    free_slots [Capacity];
    int unsigned         free_top;
    logic [CountW-1:0]   live;
    logic [CountW-1:0]   peak;
    result_t             pending_results[$];
    int unsigned         errors;
    int unsigned         n_checked;
    int unsigned         n_full;
    int unsigned         n_ignored;
    int unsigned         n_grants;

    function new();
      taken     = '0;
      free_top  = 0;
      live      = '0;
      peak      = '0;
      errors    = 0;
      n_checked = 0;
      n_full    = 0;
      n_ignored = 0;
      n_grants  = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Random allocated slot, or any slot when the pool is empty.
    function logic [SlotW-1:0] any_taken();
      int unsigned start;
      start = $urandom_range(0, Capacity - 1);
      for (int unsigned i = 0; i < Capacity; i++) begin
        if (taken[(start + i) % Capacity]) return SlotW'((start + i) % Capacity);
      end
      return SlotW'(start);
    endfunction

    // slot_index is 8 bits wide, so it can never reach Capacity: no range case here.
    function void note_request(op_e op, logic [SlotW-1:0] idx);
      result_t r;
      r.granted_slot = idx;
      r.status       = STAT_DONE;
      r.is_allocated = 1'b0;
      case (op)
        OP_RESERVE: begin
          if (live >= Capacity) begin
            r.status       = STAT_FULL;
            r.granted_slot = '0;
            n_full++;
          end else begin
            if (free_top > 0) begin
              free_top--;
              r.granted_slot = free_slots[free_top];
            end else begin
              r.granted_slot = live[SlotW-1:0];
            end
            taken[r.granted_slot] = 1'b1;
            live++;
            if (live > peak) peak = live;
            r.is_allocated = 1'b1;
            n_grants++;
          end
        end
        OP_RELEASE: begin
          if (live == 0 || !taken[idx]) begin
            // empty pool or slot already free
            r.status       = STAT_IGNORED;
            r.is_allocated = taken[idx];
            n_ignored++;
          end else begin
            if (free_top < Capacity) begin
              free_slots[free_top] = idx;
              free_top++;
            end
            taken[idx] = 1'b0;
            live--;
          end
        end
        OP_LOOKUP: r.is_allocated = taken[idx];
        default: ;
      endcase
      r.live_count = live;
      r.peak_count = peak;
      pending_results.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutW-1:0] data);
      result_t got, want;
      got = result_t'(data[ResultW-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result 0x%08h with nothing pending", data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      report("granted_slot", want.granted_slot, got.granted_slot);
      report("status",       want.status,       got.status);
      report("is_allocated", want.is_allocated, got.is_allocated);
      report("live_count",   want.live_count,   got.live_count);
      report("peak_count",   want.peak_count,   got.peak_count);
    endfunction
  endclass

  slot_ledger   ledger;
  int unsigned  cycles = 0;
  int unsigned  send_quiet = 0;
  int unsigned  recv_quiet = 0;

  slot_pool_allocator_unit #(.CAPACITY(Capacity)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap length for one side; occasional stretches of back-to-back traffic.
  function automatic int unsigned draw_gap(ref int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // tvalid still high so the next request can follow without a bubble.
  task automatic send_request(op_e op, logic [SlotW-1:0] idx);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = idx;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_request(op, idx);
    @(negedge clk_i);
  endtask

  // phase 0/2 fill, 1/4 drain, 3 mixed
  task automatic send_random(int unsigned phase);
    int unsigned r;
    int unsigned p_res, p_rel, p_look;
    r = $urandom_range(0, 99);
    case (phase)
      0, 2:    begin p_res = 85; p_rel = 93; p_look = 97; end
      1, 4:    begin p_res = 8;  p_rel = 88; p_look = 95; end
      default: begin p_res = 40; p_rel = 70; p_look = 90; end
    endcase
    if (r < p_res)       send_request(OP_RESERVE, SlotW'($urandom));
    else if (r < p_rel)  send_request(OP_RELEASE, ledger.any_taken());
    else if (r < p_look) begin
      if ($urandom_range(0, 1)) send_request(OP_LOOKUP, ledger.any_taken());
      else                      send_request(OP_LOOKUP, SlotW'($urandom));
    end else begin
      // noise: release of an arbitrary slot or the unused code
      if ($urandom_range(0, 1)) send_request(OP_RELEASE, SlotW'($urandom));
      else                      send_request(OP_UNUSED, SlotW'($urandom));
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned stall;
      @(negedge clk_i);
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      ledger.check_result(m_axis_tdata);
    end
  end

  initial begin
    ledger        = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_RESERVE;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed opener
    send_request(OP_RELEASE, 8'd0);    // empty pool
    send_request(OP_RELEASE, 8'd255);
    send_request(OP_LOOKUP,  8'd0);
    send_request(OP_LOOKUP,  8'd255);
    send_request(OP_UNUSED,  8'hFF);
    send_request(OP_UNUSED,  8'h00);
    send_request(OP_RESERVE, 8'hFF);   // index is don't-care
    send_request(OP_RESERVE, 8'h55);
    send_request(OP_RESERVE, 8'hAA);
    send_request(OP_LOOKUP,  8'd1);
    send_request(OP_RELEASE, 8'd1);
    send_request(OP_RELEASE, 8'd1);    // already free
    send_request(OP_LOOKUP,  8'd1);
    send_request(OP_RESERVE, 8'd0);    // reuses slot 1 from the stack
    send_request(OP_RELEASE, 8'd2);
    send_request(OP_RELEASE, 8'd0);
    send_request(OP_RESERVE, 8'd0);    // LIFO: slot 0 first
    send_request(OP_RESERVE, 8'd0);
    send_request(OP_RESERVE, 8'd0);    // fresh slot again
    send_request(OP_LOOKUP,  8'd255);
    send_request(OP_RELEASE, 8'd200);

    for (int unsigned i = 0; i < RandItems; i++) send_random(i / PhaseLen);
    s_axis_tvalid = 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results: %0d grants, %0d pool-full, %0d ignored releases,",
             ledger.n_checked, ledger.n_grants, ledger.n_full, ledger.n_ignored);
    $display("peak occupancy %0d of %0d slots.", ledger.peak, Capacity);
    if (ledger.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/spa_pkg.sv
src/spa_ram.sv
src/slot_pool_allocator_unit.sv
src/spa_checker.sv
bench/tb_slot_pool_allocator_unit.sv
